// ===== rtl/mlfd_pkg.sv =====
package mlfd_pkg;

  localparam int unsigned KEPT_BYTES_DEF = 24;

  // Payload bytes that any decoded message looks at.
  localparam int unsigned DECODE_BYTES = 24;

  localparam logic [7:0] MAGIC_BYTE = 8'hA6;
  localparam logic [7:0] TYPE_HELLO = 8'h02;
  localparam logic [7:0] TYPE_ACK   = 8'h03;
  localparam logic [7:0] TYPE_CHAN  = 8'h12;
  localparam logic [7:0] TYPE_BATCH = 8'h21;
  localparam logic [7:0] TYPE_STATS = 8'h31;

  localparam logic [15:0] HELLO_MIN_LEN = 16'd6;
  localparam logic [15:0] CHAN_MIN_LEN  = 16'd2;
  localparam logic [15:0] STATS_MIN_LEN = 16'd24;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_FLAGS = 3'd2,
    PH_SEQ   = 3'd3,
    PH_LENLO = 3'd4,
    PH_LENHI = 3'd5,
    PH_DATA  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HELLO = 3'd0,
    KIND_ACK   = 3'd1,
    KIND_CHAN  = 3'd2,
    KIND_STATS = 3'd3,
    KIND_BATCH = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic [31:0] word_e;
    logic [31:0] word_f;
    logic [7:0]  batch_data;
    logic        batch_last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } decode_t;

  typedef logic [DECODE_BYTES-1:0][7:0] head_t;

  // Little-endian word from four consecutive head bytes.
  function automatic logic [31:0] head_word(head_t h, int unsigned off);
    head_word = {h[off+3], h[off+2], h[off+1], h[off]};
  endfunction

  function automatic decode_t decode(logic [7:0] mtype, logic [15:0] len, head_t h);
    decode_t r;
    r = '0;
    case (mtype)
      TYPE_HELLO: begin
        if (len >= HELLO_MIN_LEN) begin
          r.valid      = 1'b1;
          r.res.kind   = KIND_HELLO;
          r.res.word_a = {24'h0, h[0]};
          r.res.word_b = {24'h0, h[1]};
          r.res.word_c = head_word(h, 2);
        end
      end
      TYPE_ACK: begin
        r.valid    = 1'b1;
        r.res.kind = KIND_ACK;
      end
      TYPE_CHAN: begin
        if (len >= CHAN_MIN_LEN) begin
          r.valid      = 1'b1;
          r.res.kind   = KIND_CHAN;
          r.res.word_a = {24'h0, h[0]};
          r.res.word_b = {24'h0, h[1]};
        end
      end
      TYPE_STATS: begin
        if (len >= STATS_MIN_LEN) begin
          r.valid      = 1'b1;
          r.res.kind   = KIND_STATS;
          r.res.word_a = head_word(h, 0);
          r.res.word_b = head_word(h, 4);
          r.res.word_c = head_word(h, 8);
          r.res.word_d = head_word(h, 12);
          r.res.word_e = head_word(h, 16);
          r.res.word_f = head_word(h, 20);
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mlfd_in_reg.sv =====
module mlfd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_resync_i,
  input  logic       advance_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o,
  output logic       held_resync_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       resync_q;
  logic       load;

  // The held word may be replaced in the same cycle it moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= in_byte_i;
      resync_q <= in_resync_i;
    end
  end

  assign held_valid_o  = valid_q;
  assign held_byte_o   = byte_q;
  assign held_resync_o = resync_q;

endmodule

// ===== rtl/mlfd_core.sv =====
module mlfd_core #(
  parameter int unsigned KEPT_BYTES = mlfd_pkg::KEPT_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              resync_i,
  output logic              res_valid_o,
  output mlfd_pkg::result_t res_o
);

  localparam int unsigned IdxW = $clog2(KEPT_BYTES);

  mlfd_pkg::phase_e phase_q, phase_d;
  logic [7:0]       type_q, type_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      idx_q, idx_d;
  logic [7:0]       head_q [KEPT_BYTES];

  logic [15:0]       idx_inc;
  logic [15:0]       len_full;
  logic              last;
  logic              in_data;
  logic              keep;
  mlfd_pkg::head_t   head_view;
  mlfd_pkg::decode_t dec;

  assign idx_inc  = idx_q + 16'd1;
  assign len_full = {byte_i, len_q[7:0]};
  assign last     = (idx_inc >= len_q);
  assign in_data  = (phase_q == mlfd_pkg::PH_DATA);
  assign keep     = in_data && (idx_q < 16'(KEPT_BYTES));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (resync_i) begin
      phase_d = mlfd_pkg::PH_HUNT;
    end else begin
      case (phase_q)
        mlfd_pkg::PH_TYPE:  phase_d = mlfd_pkg::PH_FLAGS;
        mlfd_pkg::PH_FLAGS: phase_d = mlfd_pkg::PH_SEQ;
        mlfd_pkg::PH_SEQ:   phase_d = mlfd_pkg::PH_LENLO;
        mlfd_pkg::PH_LENLO: phase_d = mlfd_pkg::PH_LENHI;
        mlfd_pkg::PH_LENHI: begin
          phase_d = (len_full == 16'd0) ? mlfd_pkg::PH_HUNT : mlfd_pkg::PH_DATA;
        end
        mlfd_pkg::PH_DATA: begin
          phase_d = last ? mlfd_pkg::PH_HUNT : mlfd_pkg::PH_DATA;
        end
        default: begin
          phase_d = (byte_i == mlfd_pkg::MAGIC_BYTE) ? mlfd_pkg::PH_TYPE
                                                      : mlfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Header fields and payload counter.
  always_comb begin
    type_d = type_q;
    len_d  = len_q;
    idx_d  = idx_q;
    if (resync_i) begin
      type_d = '0;
      len_d  = '0;
      idx_d  = '0;
    end else begin
      case (phase_q)
        mlfd_pkg::PH_TYPE:  type_d = byte_i;
        mlfd_pkg::PH_LENLO: len_d  = {8'h00, byte_i};
        mlfd_pkg::PH_LENHI: begin
          len_d = len_full;
          idx_d = '0;
        end
        mlfd_pkg::PH_DATA:  idx_d = idx_inc;
        default: begin
          type_d = type_q;
        end
      endcase
    end
  end

  // The byte being written this cycle is seen by the decoder at once.
  always_comb begin
    for (int i = 0; i < int'(mlfd_pkg::DECODE_BYTES); i++) begin
      head_view[i] = (keep && (idx_q[IdxW-1:0] == IdxW'(i))) ? byte_i : head_q[i];
    end
  end

  assign dec = mlfd_pkg::decode(type_q, len_d, head_view);

  // Result of this step.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!resync_i) begin
      case (phase_q)
        mlfd_pkg::PH_LENHI: begin
          if (len_full == 16'd0 && type_q != mlfd_pkg::TYPE_BATCH) begin
            res_valid_o = dec.valid;
            res_o       = dec.res;
          end
        end
        mlfd_pkg::PH_DATA: begin
          if (type_q == mlfd_pkg::TYPE_BATCH) begin
            res_valid_o      = 1'b1;
            res_o.kind       = mlfd_pkg::KIND_BATCH;
            res_o.batch_data = byte_i;
            res_o.batch_last = last;
          end else if (last) begin
            res_valid_o = dec.valid;
            res_o       = dec.res;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mlfd_pkg::PH_HUNT;
      type_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !resync_i && keep) begin
      head_q[idx_q[IdxW-1:0]] <= byte_i;
    end
  end

endmodule

// ===== rtl/magic_length_frame_deframer.sv =====
// Deframer for a serial byte stream of packets that start with the magic byte 0xA6,
// followed by type, flags, sequence, a little-endian 16-bit length and the payload.
// One byte word is taken every cycle while the result register is free or being emptied.
// A result is registered: an accepted byte waits in the input register, and the parser's
// state update for it, which is the single step that sets this rate, loads the result
// register when the byte moves on. Each accepted byte gives at most one result: a decoded
// hello, ack, channel state or statistics message on the last payload byte (on the length
// high byte if the length is zero), or one forwarded byte per batch payload byte.
// Setting tuser on an input word drops the parser back to hunting for the magic byte.
module magic_length_frame_deframer #(
  parameter int unsigned KEPT_BYTES = mlfd_pkg::KEPT_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // rx_byte
  input  logic         s_axis_tuser_i,   // resync
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // word_a [31:0], word_b [63:32], word_c [95:64], word_d [127:96],
  // word_e [159:128], word_f [191:160], batch_data [199:192]
  output logic [199:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // kind
  output logic         m_axis_tlast_o    // batch_last
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              held_resync;
  logic              advance;
  logic              core_valid;
  mlfd_pkg::result_t core_res;

  logic              out_valid_q, out_valid_d;
  mlfd_pkg::result_t out_q;

  // A held byte moves on whenever the result register is free or being emptied.
  assign advance = held_valid && (!out_valid_q || m_axis_tready_i);

  mlfd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_resync_i  (s_axis_tuser_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte),
    .held_resync_o(held_resync)
  );

  mlfd_core #(
    .KEPT_BYTES(KEPT_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (held_byte),
    .resync_i   (held_resync),
    .res_valid_o(core_valid),
    .res_o      (core_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = core_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.batch_data, out_q.word_f, out_q.word_e, out_q.word_d,
                            out_q.word_c, out_q.word_b, out_q.word_a};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.batch_last;

endmodule
